>>> sv/assert_macros.svh
// Assertion helpers for the hash table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, checked on every clock
`define ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

>>> sv/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;
	localparam logic [63:0] HASH_SEED = 64'h13371337deadbeef;
	localparam int CHAR_BITS = 8;
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;
	localparam logic [0:0] REG_CAPACITY = 1'b0;
endpackage

>>> sv/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht_req_if / lpht_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface lpht_req_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [63:0] key;
	logic [3:0] key_length;
	logic [31:0] value;
	modport source (output valid, cmd, key, key_length, value, input ready);
	modport sink (input valid, cmd, key, key_length, value, output ready);
endinterface

interface lpht_rsp_if;
	logic valid;
	logic ready;
	logic found;
	logic [31:0] read_value;
	logic status;
	logic [8:0] entry_count;
	modport source (output valid, found, read_value, status, entry_count, input ready);
	modport sink (input valid, found, read_value, status, entry_count, output ready);
endinterface

>>> sv/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Key-value store with open addressing and linear probing.
// ----------------------------------------------------------------------------
// Usage: requests enter on the req channel (valid/ready); one result item
// leaves on rsp per request. Capacity is set through the APB port at address
// 0 by the user, only while idle; the block itself does not enforce this. A
// request is hashed, reduced modulo the capacity and its start slot loaded;
// then each visited slot takes a memory read and then a compare, with the
// write-back on the compare step, and an output state follows.
// A probe run that reaches its limit visits one slot more than it probed.
// One request is in flight at a time; ready is high only when no request is
// being worked and no result is waiting, so the next request is taken no
// earlier than the cycle after the result is taken.
// The rate is set by the bit-serial modulo unit and the probing of one slot at a time.
// After reset a clearing pass over every slot resets the valid bits; no
// request is taken meanwhile. A stalled receiver holds the result register
// and the block accepts no new request until it is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lpht_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_CHARS = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	lpht_req_if.sink    req,
	lpht_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
`include "assert_macros.svh"
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int VB = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
	localparam logic [8:0] DEPTH9 = (TABLE_DEPTH > 256) ? 9'd256 : 9'(TABLE_DEPTH);
	localparam int EW = 64 + 4 + VB + 1;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_HASH = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [EW-1:0] mem [TABLE_DEPTH];
	logic [EW-1:0] rd_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;

	logic [2:0] state_q;
	logic [8:0] cap_q;
	logic [8:0] cap_eff;
	logic [8:0] count_q;
	logic       cmd_q;
	logic [63:0] key_q;
	logic [3:0] len_q;
	logic [VB-1:0] val_q;
	logic [8:0] slot_q;
	logic [8:0] probe_q;
	logic [AW-1:0] clr_q;
	logic       hstart;
	logic       hdone;
	logic [8:0] hslot;
	logic [3:0] len_in;
	logic [63:0] kmask;
	logic        e_valid;
	logic [63:0] e_key;
	logic [3:0]  e_len;
	logic [VB-1:0] e_val;
	logic        match;
	logic [8:0]  limit;
	logic [8:0]  nslot;

	assign cap_eff = (cap_q == 9'd0) ? 9'd1 : (cap_q > DEPTH9) ? DEPTH9 : cap_q;
	assign len_in = (req.key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : req.key_length;
	always_comb begin
		kmask = '0;
		for (int i = 0; i < 8; i++)
			if (i < int'(len_in)) kmask[i*8 +: 8] = 8'hff;
	end

	assign pready = 1'b1;
	assign prdata = {23'd0, cap_q};

	assign req.ready = (state_q == ST_IDLE) && !rsp.valid;
	assign hstart = req.valid && req.ready;

	lpht_hash #(.CAP_BITS(9)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(hstart), .key(req.key & kmask),
		.key_length(len_in), .cap(cap_eff), .done(hdone), .slot(hslot)
	);

	assign {e_valid, e_key, e_len, e_val} = rd_q;
	assign match = e_valid && e_len == len_q && e_key == key_q;
	assign limit = (cmd_q == CMD_PUT) ? cap_eff - 9'd1 : cap_eff;
	assign nslot = (slot_q + 9'd1 == cap_eff) ? 9'd0 : slot_q + 9'd1;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[slot_q[AW-1:0]];
	end

	always_comb begin
		we = 1'b0;
		waddr = slot_q[AW-1:0];
		wdata = {1'b1, key_q, len_q, val_q};
		if (state_q == ST_CLR) begin
			we = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == ST_CMP && probe_q < limit && cmd_q == CMD_PUT &&
				(match || !e_valid)) begin
			we = 1'b1;
			if (match) wdata = {1'b1, e_key, e_len, val_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			cap_q <= DEPTH9;
			count_q <= '0;
			rsp.valid <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr[1:0] == {REG_CAPACITY, 1'b0})
				cap_q <= pwdata[8:0];
			if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (hstart) begin
						cmd_q <= req.cmd;
						key_q <= req.key & kmask;
						len_q <= len_in;
						val_q <= req.value[VB-1:0];
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hdone) begin
						slot_q <= hslot;
						probe_q <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_CMP;
				ST_CMP: begin
					rsp.found <= 1'b0;
					rsp.read_value <= '0;
					rsp.status <= cmd_q;
					rsp.entry_count <= count_q;
					if (probe_q >= limit) begin
						state_q <= ST_OUT;
					end else if (cmd_q == CMD_GET && (!e_valid || match)) begin
						rsp.found <= match;
						rsp.read_value <= match ? 32'(e_val) : 32'd0;
						state_q <= ST_OUT;
					end else if (cmd_q == CMD_PUT && (!e_valid || match)) begin
						rsp.status <= 1'b0;
						if (!e_valid) begin
							count_q <= count_q + 9'd1;
							rsp.entry_count <= count_q + 9'd1;
						end
						state_q <= ST_OUT;
					end else begin
						slot_q <= nslot;
						probe_q <= probe_q + 9'd1;
						state_q <= ST_RD;
					end
				end
				ST_OUT: begin
					if (!rsp.valid) begin
						rsp.valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMP(a_ready_idle, clk, arst_n, req.ready, !rsp.valid || state_q == ST_IDLE)
	`ASSERT_NXT(a_one_rsp, clk, arst_n, hstart, state_q == ST_HASH)
	`ASSERT_IMP(a_count_cap, clk, arst_n, 1'b1, count_q <= DEPTH9)
endmodule

>>> sv/lpht_hash.sv
// ----------------------------------------------------------------------------
// lpht_hash
// Hashes one character per cycle, then reduces modulo capacity by
// restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpht_hash import lpht_pkg::*; #(
	parameter int CAP_BITS = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         key,
	input  logic [3:0]          key_length,
	input  logic [CAP_BITS-1:0] cap,
	output logic                done,
	output logic [CAP_BITS-1:0] slot
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HASH = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	logic [1:0] state_q;
	logic [63:0] h_q;
	logic [63:0] key_q;
	logic [3:0] left_q;
	logic [6:0] bit_q;
	logic [CAP_BITS:0] rem_q;
	logic [7:0] c;
	logic [63:0] hx;
	logic [CAP_BITS:0] rsh;

	assign c = key_q[7:0];
	assign hx = h_q ^ {56'd0, c};
	assign rsh = {rem_q[CAP_BITS-1:0], h_q[bit_q[5:0]]};
	assign slot = rem_q[CAP_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						h_q <= HASH_SEED;
						key_q <= key;
						left_q <= key_length;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (left_q == 4'd0) begin
						rem_q <= '0;
						bit_q <= 7'd63;
						state_q <= ST_DIV;
					end else begin
						h_q <= {hx[55:0], 8'd0} + {56'd0, c};
						key_q <= {8'd0, key_q[63:8]};
						left_q <= left_q - 4'd1;
					end
				end
				ST_DIV: begin
					rem_q <= (rsh >= {1'b0, cap}) ? rsh - {1'b0, cap} : rsh;
					bit_q <= bit_q - 7'd1;
					if (bit_q == 7'd0) begin
						state_q <= ST_IDLE;
						done <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the linear probing hash table against a behavioral table model.
// A directed table covers key and capacity corners, then random get/put
// traffic runs over a recurring key set at several capacities, with random
// idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import lpht_pkg::*;

	localparam int DEPTH = 256;
	localparam int LIMIT_CYCLES = 4000000;
	localparam int POOL_SIZE = 48;

	typedef struct packed {
		logic       found;
		logic [31:0] read_value;
		logic       status;
		logic [8:0] entry_count;
	} lookup_result_t;

	typedef struct {
		bit          set_cap;
		logic [8:0]  cap;
		logic        cmd;
		logic [63:0] key;
		logic [3:0]  key_length;
		logic [31:0] value;
		bit          typed;
		lookup_result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	lpht_req_if req_ch ();
	lpht_rsp_if rsp_ch ();

	linear_probe_hash_table u_top (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// table model state
	logic [8:0]  tbl_capacity;
	bit          tbl_valid [DEPTH];
	logic [63:0] tbl_key [DEPTH];
	logic [3:0]  tbl_len [DEPTH];
	logic [31:0] tbl_value [DEPTH];
	int unsigned tbl_count;

	lookup_result_t pending_results[$];
	lookup_result_t typed_result;
	bit use_typed;
	int errors;
	int tx_idle_pct, rx_idle_pct;
	int hold_request;
	int hold_left;
	longint unsigned cycles;

	logic [63:0] pool_key [POOL_SIZE];
	logic [3:0]  pool_len [POOL_SIZE];

	function automatic lookup_result_t hash_table_lookup(logic cmd, logic [63:0] key_in,
			logic [3:0] len_in, logic [31:0] val);
		int unsigned cap, n, start, s, i;
		logic [63:0] k, h, c;
		lookup_result_t r;
		cap = (tbl_capacity == 0) ? 1 : (tbl_capacity > DEPTH) ? DEPTH : tbl_capacity;
		n = (len_in > 8) ? 8 : len_in;
		k = (n >= 8) ? key_in : key_in & ((64'h1 << (8 * n)) - 64'h1);
		h = HASH_SEED;
		for (i = 0; i < n; i++) begin
			c = {56'h0, k[8*i +: 8]};
			h = h ^ c;
			h = h << 8;
			h = h + c;
		end
		start = 32'(h % cap);
		r = '0;
		if (cmd == CMD_GET) begin
			for (i = 0; i < cap; i++) begin
				s = (start + i) % cap;
				if (!tbl_valid[s])
					break;
				if (tbl_len[s] == n && tbl_key[s] == k) begin
					r.found = 1'b1;
					r.read_value = tbl_value[s];
					break;
				end
			end
		end else begin
			r.status = 1'b1;
			for (i = 0; i + 1 < cap; i++) begin
				s = (start + i) % cap;
				if (tbl_valid[s] && tbl_len[s] == n && tbl_key[s] == k) begin
					tbl_value[s] = val;
					r.status = 1'b0;
					break;
				end
				if (!tbl_valid[s]) begin
					tbl_valid[s] = 1'b1;
					tbl_key[s] = k;
					tbl_len[s] = 4'(n);
					tbl_value[s] = val;
					tbl_count++;
					r.status = 1'b0;
					break;
				end
			end
		end
		r.entry_count = tbl_count[8:0];
		return r;
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= LIMIT_CYCLES) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	// result checking and expectation capture
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected item", rsp_ch.entry_count, 0);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.found !== want.found)
					report_mismatch("found", rsp_ch.found, want.found);
				if (rsp_ch.read_value !== want.read_value)
					report_mismatch("read_value", rsp_ch.read_value, want.read_value);
				if (rsp_ch.status !== want.status)
					report_mismatch("status", rsp_ch.status, want.status);
				if (rsp_ch.entry_count !== want.entry_count)
					report_mismatch("entry_count", rsp_ch.entry_count, want.entry_count);
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			want = hash_table_lookup(req_ch.cmd, req_ch.key, req_ch.key_length, req_ch.value);
			pending_results.push_back(use_typed ? typed_result : want);
		end
	end

	// receiver: random idling plus an optional long hold-off
	initial begin
		rsp_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic write_capacity(logic [8:0] cap);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {1'b0, REG_CAPACITY};
		pwdata <= {23'h0, cap};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tbl_capacity = cap;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_item(logic cmd, logic [63:0] key, logic [3:0] len, logic [31:0] val);
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.key <= key;
		req_ch.key_length <= len;
		req_ch.value <= val;
		do @(posedge clk); while (!req_ch.ready);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic end_burst();
		req_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	stim_row_t directed [$];

	function automatic stim_row_t row(bit set_cap, logic [8:0] cap, logic cmd,
			logic [63:0] key, logic [3:0] len, logic [31:0] val, bit typed,
			logic found, logic [31:0] rv, logic st, logic [8:0] cnt);
		stim_row_t r;
		r.set_cap = set_cap;
		r.cap = cap;
		r.cmd = cmd;
		r.key = key;
		r.key_length = len;
		r.value = val;
		r.typed = typed;
		r.res = '{found, rv, st, cnt};
		return r;
	endfunction

	initial begin
		int ph, seg, n, p;
		logic [8:0] seg_caps [15];
		logic [63:0] k, m;
		logic [3:0] len;
		logic c;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_GET;
		req_ch.key = '0;
		req_ch.key_length = '0;
		req_ch.value = '0;
		errors = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_request = 0;
		use_typed = 1'b0;
		typed_result = '0;
		tbl_capacity = 9'(DEPTH);
		tbl_count = 0;
		for (int i = 0; i < DEPTH; i++)
			tbl_valid[i] = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_key[i] = {$urandom, $urandom};
			pool_len[i] = 4'($urandom_range(8));
		end
		pool_key[0] = '0;
		pool_len[0] = 4'd8;
		pool_key[1] = 64'hffff_ffff_ffff_ffff;
		pool_len[1] = 4'd8;
		seg_caps = '{9'd16, 9'd3, 9'd61, 9'd256, 9'd7, 9'd2, 9'd100, 9'd1,
			9'd16, 9'd511, 9'd29, 9'd8, 9'd0, 9'd5, 9'd256};

		// directed corners
		directed.push_back(row(0, 0, CMD_GET, 64'h0, 4'd0, 32'h0, 1, 0, 0, 0, 9'd0));
		directed.push_back(row(0, 0, CMD_PUT, '1, 4'd8, '1, 1, 0, 0, 0, 9'd1));
		directed.push_back(row(0, 0, CMD_GET, '1, 4'd8, 32'h0, 1, 1, '1, 0, 9'd1));
		directed.push_back(row(0, 0, CMD_GET, '1, 4'd15, 32'h5, 1, 1, '1, 0, 9'd1));
		directed.push_back(row(0, 0, CMD_PUT, 64'h0, 4'd0, 32'h0, 1, 0, 0, 0, 9'd2));
		directed.push_back(row(0, 0, CMD_PUT, 64'hdead_beef_0041_4243, 4'd3, 32'd123,
			0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, CMD_GET, 64'h1234_5678_9a41_4243, 4'd3, 32'h0,
			0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, CMD_PUT, 64'h0, 4'd4, 32'hcafe, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, CMD_GET, 64'h0, 4'd3, 32'h0, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, CMD_PUT, 64'h0, 4'd4, 32'h8000_0001, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, CMD_PUT, 64'h80ff_7f01_00fe_8081, 4'd8, 32'h1,
			0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, CMD_GET, 64'h0, 4'd4, 32'h0, 0, 0, 0, 0, 0));
		directed.push_back(row(1, 9'd1, CMD_PUT, 64'h55, 4'd1, 32'h7, 1, 0, 0, 1, 9'd5));
		directed.push_back(row(0, 0, CMD_GET, 64'h55, 4'd1, 32'h0, 0, 0, 0, 0, 0));
		directed.push_back(row(1, 9'd0, CMD_PUT, 64'h66, 4'd1, 32'h7, 1, 0, 0, 1, 9'd5));
		directed.push_back(row(1, 9'd511, CMD_GET, '1, 4'd8, 32'h0, 1, 1, '1, 0, 9'd5));
		directed.push_back(row(1, 9'd3, CMD_PUT, 64'h01, 4'd1, 32'h11, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, CMD_PUT, 64'h02, 4'd1, 32'h22, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, CMD_PUT, 64'h03, 4'd1, 32'h33, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, CMD_PUT, 64'h04, 4'd1, 32'h44, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, CMD_GET, 64'h02, 4'd1, 32'h0, 0, 0, 0, 0, 0));
		directed.push_back(row(1, 9'd2, CMD_PUT, 64'h05, 4'd2, 32'h55, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, CMD_GET, 64'h05, 4'd2, 32'h0, 0, 0, 0, 0, 0));

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].set_cap) begin
				end_burst();
				wait_drained();
				write_capacity(directed[i].cap);
			end
			use_typed <= directed[i].typed;
			typed_result <= directed[i].res;
			send_item(directed[i].cmd, directed[i].key, directed[i].key_length,
				directed[i].value);
		end
		end_burst();
		wait_drained();
		use_typed <= 1'b0;

		// random traffic in three idling phases
		for (ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 81 : 0;
			rx_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 9 : 0;
			for (seg = 0; seg < 5; seg++) begin
				end_burst();
				wait_drained();
				write_capacity(seg_caps[ph * 5 + seg]);
				if (ph == 2 && seg == 1)
					hold_request = 600;
				for (n = 0; n < 102; n++) begin
					c = 1'($urandom_range(1));
					if ($urandom_range(99) < 8) begin
						k = {$urandom, $urandom};
						len = 4'($urandom_range(15));
					end else begin
						p = $urandom_range(POOL_SIZE - 1);
						len = pool_len[p];
						m = (len >= 8) ? '1 : (64'h1 << (8 * len)) - 64'h1;
						k = (pool_key[p] & m) | ({$urandom, $urandom} & ~m);
						if (len == 8 && $urandom_range(1))
							len = 4'($urandom_range(15, 8));
					end
					send_item(c, k, len, $urandom);
				end
			end
		end
		end_burst();
		wait_drained();
		repeat (800) @(posedge clk);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
